[hw/rtl/sensor_frame_receiver_unit_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the sensor frame receiver
// Shared same-cycle-implication and next-cycle-implication property wrappers.
// ---------------------------------------------------------------------------
`ifndef SENSOR_FRAME_RECEIVER_UNIT_MACROS_SVH
`define SENSOR_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfr assertion failed");

// Next-cycle implication, disabled during reset.
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfr assertion failed");

`endif

[hw/rtl/sfr_pkg.sv]
// ---------------------------------------------------------------------------
// Sensor frame receiver package
// Header codes, frame lengths, register indexes and shared types.
// ---------------------------------------------------------------------------
package sfr_pkg;

   localparam logic [7:0] HDR_UPLOAD = 8'h42;
   localparam logic [7:0] HDR_QUERY  = 8'hFF;

   // Frame lengths, one bit wider than the index so 32 fits
   localparam logic [5:0] LEN_UPLOAD_SHORT = 6'd24;
   localparam logic [5:0] LEN_UPLOAD_LONG  = 6'd32;
   localparam logic [5:0] LEN_QUERY        = 6'd9;

   // Register indexes (byte address bit 2)
   localparam logic CSR_OP_MODE      = 1'b0;
   localparam logic CSR_SENSOR_MODEL = 1'b1;

   typedef enum logic {
      MODE_UPLOAD = 1'b0,
      MODE_QUERY  = 1'b1
   } op_mode_type;

   typedef enum logic {
      MODEL_SHORT = 1'b0,
      MODEL_LONG  = 1'b1
   } sensor_model_type;

   // Per-byte decision handed from the frame tracker to the output stage
   typedef struct packed {
      logic       emit;
      logic [4:0] byte_index;
      logic       frame_end;
      logic       frame_ok;
   } sfr_result_type;

endpackage

[hw/rtl/sfr_frame_tracker.sv]
// ---------------------------------------------------------------------------
// Sensor frame receiver frame tracker
// Header hunt, byte counting and checksum check, one byte per cycle on step.
// ---------------------------------------------------------------------------
module sfr_frame_tracker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  logic                      step,
   input  logic [7:0]                rx_byte,
   input  sfr_pkg::op_mode_type      op_mode,
   input  sfr_pkg::sensor_model_type sensor_model,
   output sfr_pkg::sfr_result_type   res
);

`include "sensor_frame_receiver_unit_macros.svh"

   logic        in_frame_ff,   in_frame_in;
   logic [4:0]  byte_count_ff, byte_count_in;
   logic [15:0] sum_ff,        sum_in;
   logic [7:0]  held_hi_ff,    held_hi_in;

   logic        is_query;
   logic [7:0]  hdr;
   logic [5:0]  len;
   logic [4:0]  idx;
   logic [5:0]  idx_p1;
   logic [5:0]  idx_p2;
   logic [15:0] sum_cur;
   logic [7:0]  held_cur;
   logic [7:0]  sum8_next;
   logic [7:0]  neg8;
   logic        hit;
   logic        done;
   logic        ok;
   logic [15:0] sum_next;
   logic [7:0]  held_next;

   always_comb begin
      is_query = (op_mode == sfr_pkg::MODE_QUERY);
      hdr      = is_query ? sfr_pkg::HDR_QUERY : sfr_pkg::HDR_UPLOAD;
      if (is_query) begin
         len = sfr_pkg::LEN_QUERY;
      end else if (sensor_model == sfr_pkg::MODEL_LONG) begin
         len = sfr_pkg::LEN_UPLOAD_LONG;
      end else begin
         len = sfr_pkg::LEN_UPLOAD_SHORT;
      end

      // a header byte starts from a cleared frame
      hit      = in_frame_ff || (rx_byte == hdr);
      idx      = in_frame_ff ? byte_count_ff : 5'd0;
      sum_cur  = in_frame_ff ? sum_ff : 16'd0;
      held_cur = in_frame_ff ? held_hi_ff : 8'd0;
      idx_p1   = {1'b0, idx} + 6'd1;
      idx_p2   = {1'b0, idx} + 6'd2;

      sum8_next = sum_cur[7:0] + rx_byte;
      neg8      = 8'd0 - sum_cur[7:0];

      done      = 1'b0;
      ok        = 1'b0;
      sum_next  = sum_cur;
      held_next = held_cur;

      if (!is_query) begin
         if (idx_p2 < len) begin
            sum_next = sum_cur + {8'd0, rx_byte};
         end else if (idx_p2 == len) begin
            held_next = rx_byte;
         end else begin
            done = 1'b1;
            ok   = (sum_cur == {held_cur, rx_byte});
         end
      end else begin
         if ((idx != 5'd0) && (idx_p1 < len)) begin
            sum_next = {8'd0, sum8_next};
         end else if (idx_p1 >= len) begin
            done = 1'b1;
            ok   = (neg8 == rx_byte);
         end
      end

      res.emit       = hit;
      res.byte_index = idx;
      res.frame_end  = done;
      res.frame_ok   = done && ok;
   end

   always_comb begin
      in_frame_in   = in_frame_ff;
      byte_count_in = byte_count_ff;
      sum_in        = sum_ff;
      held_hi_in    = held_hi_ff;
      if (clear) begin
         in_frame_in   = 1'b0;
         byte_count_in = 5'd0;
         sum_in        = 16'd0;
         held_hi_in    = 8'd0;
      end else if (step && hit) begin
         if (done) begin
            in_frame_in   = 1'b0;
            byte_count_in = 5'd0;
            sum_in        = 16'd0;
            held_hi_in    = 8'd0;
         end else begin
            in_frame_in   = 1'b1;
            byte_count_in = idx + 5'd1;
            sum_in        = sum_next;
            held_hi_in    = held_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         byte_count_ff <= 5'd0;
         sum_ff        <= 16'd0;
         held_hi_ff    <= 8'd0;
      end else begin
         in_frame_ff   <= in_frame_in;
         byte_count_ff <= byte_count_in;
         sum_ff        <= sum_in;
         held_hi_ff    <= held_hi_in;
      end
   end

   `SFR_ASSERT_NEXT(a_end_returns_to_hunt, clock, reset, step && res.emit && res.frame_end, !in_frame_ff)
   `SFR_ASSERT_NEXT(a_drop_stays_hunting, clock, reset, step && !res.emit, !in_frame_ff)
   `SFR_ASSERT_IMPL(a_end_on_last_index, clock, reset, res.emit && res.frame_end, idx_p1 == len)
   `SFR_ASSERT_IMPL(a_ok_only_at_end, clock, reset, res.frame_ok, res.frame_end)

endmodule

[hw/rtl/sensor_frame_receiver_unit.sv]
// ---------------------------------------------------------------------------
// Sensor frame receiver unit
// Hunts for the frame header of the selected mode, tags each frame byte with
// its index and flags the last byte with the checksum result.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   req_     in         req_valid / req_stall     req_rx_byte
//   rsp_     out        rsp_valid / rsp_stall     rsp_byte_index, rsp_data_byte,
//                                                 rsp_frame_end, rsp_frame_ok
//   csr_     in/out     APB write/read            op_mode (0x0), sensor_model (0x4)
//
// One item per cycle sustained while rsp_stall is low; an accepted item lands in
// the input register, then the result register, and shows on rsp_ from there.
// The rate is set by the single tracker pass between the two registers.
// Reset is synchronous: back to hunting, both registers come up empty.
// A stalled result holds; the input register still advances bytes that are
// dropped while hunting, and stalls req_ only when a result has nowhere to go.
// ---------------------------------------------------------------------------
module sensor_frame_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_byte_index,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_frame_end,
   output logic        rsp_frame_ok,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // configuration registers
   sfr_pkg::op_mode_type      op_mode_ff,      op_mode_in;
   sfr_pkg::sensor_model_type sensor_model_ff, sensor_model_in;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [4:0] out_index_ff, out_index_in;
   logic [7:0] out_data_ff,  out_data_in;
   logic       out_end_ff,   out_end_in;
   logic       out_ok_ff,    out_ok_in;

   logic                    csr_write;
   logic                    out_free;
   logic                    advance;
   logic                    req_accept;
   sfr_pkg::sfr_result_type res;

   // -- configuration port --------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      op_mode_in      = op_mode_ff;
      sensor_model_in = sensor_model_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            sfr_pkg::CSR_OP_MODE: begin
               op_mode_in = sfr_pkg::op_mode_type'(csr_pwdata[0]);
            end
            sfr_pkg::CSR_SENSOR_MODEL: begin
               sensor_model_in = sfr_pkg::sensor_model_type'(csr_pwdata[0]);
            end
            default: begin
               op_mode_in = op_mode_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         sfr_pkg::CSR_OP_MODE:      csr_prdata = {31'd0, op_mode_ff};
         sfr_pkg::CSR_SENSOR_MODEL: csr_prdata = {31'd0, sensor_model_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // -- flow control ----------------------------------------------------------
   // Result slot is free when empty or being taken this cycle.
   assign out_free   = !out_valid_ff || !rsp_stall;
   // Dropped bytes never need the result slot.
   assign advance    = in_valid_ff && (!res.emit || out_free);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // -- frame tracking --------------------------------------------------------
   // Any register write abandons the frame in progress.
   sfr_frame_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .clear        (csr_write),
      .step         (advance),
      .rx_byte      (in_byte_ff),
      .op_mode      (op_mode_ff),
      .sensor_model (sensor_model_ff),
      .res          (res)
   );

   // -- result register -------------------------------------------------------
   always_comb begin
      out_valid_in = rsp_stall ? out_valid_ff : 1'b0;
      out_index_in = out_index_ff;
      out_data_in  = out_data_ff;
      out_end_in   = out_end_ff;
      out_ok_in    = out_ok_ff;
      if (advance && res.emit) begin
         out_valid_in = 1'b1;
         out_index_in = res.byte_index;
         out_data_in  = in_byte_ff;
         out_end_in   = res.frame_end;
         out_ok_in    = res.frame_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff      <= sfr_pkg::MODE_UPLOAD;
         sensor_model_ff <= sfr_pkg::MODEL_SHORT;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         op_mode_ff      <= op_mode_in;
         sensor_model_ff <= sensor_model_in;
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      out_index_ff <= out_index_in;
      out_data_ff  <= out_data_in;
      out_end_ff   <= out_end_in;
      out_ok_ff    <= out_ok_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_byte_index = out_index_ff;
   assign rsp_data_byte  = out_data_ff;
   assign rsp_frame_end  = out_end_ff;
   assign rsp_frame_ok   = out_ok_ff;

endmodule
